// File: src/wmse_pkg.sv
// Shared types and constants for the windowed mean / deviation estimator.
// No dependencies; imported by wmse_div, wmse_sqrt and the top level.
package wmse_pkg;

	// Default sizing of the estimator bank
	localparam int WINDOW_DEF    = 32;
	localparam int NUM_DIST_DEF  = 5;
	localparam int NUM_TASKS_DEF = 8;

	// Field widths fixed by the interface
	localparam int SLOT_W  = 3;
	localparam int DIST_W  = 3;
	localparam int OBS_W   = 40;
	localparam int VAL_W   = 31;
	localparam int DEV_W   = 32;
	localparam int CNT_OUT_W = 6;

	// Configuration register resets
	localparam logic [30:0] CAP_RESET      = 31'd2000000000;
	localparam logic [5:0]  MINCOUNT_RESET = 6'd10;
	localparam logic [3:0]  NUM_RESET      = 4'd2;
	localparam logic [3:0]  DEN_RESET      = 4'd1;

	// Register indexes on the APB port (byte address = 4 * index)
	localparam logic [1:0] REG_CAP      = 2'd0;
	localparam logic [1:0] REG_MINCOUNT = 2'd1;
	localparam logic [1:0] REG_NUM      = 2'd2;
	localparam logic [1:0] REG_DEN      = 2'd3;

	// Divider sizing: divisor covers a count up to 256, dividend is left aligned
	localparam int DIV_W      = 64;
	localparam int DIV_DW     = 9;
	localparam int DIV_STEP_W = 7;
	localparam int RANGE_W    = DEV_W + 4;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_CAP  = 2'd1,
		STAT_LOW  = 2'd2,
		STAT_HIGH = 2'd3
	} status_t;

	typedef struct packed {
		logic [SLOT_W-1:0] task_slot;
		logic [DIST_W-1:0] distance;
		logic [OBS_W-1:0]  observed;
	} obs_t;

	typedef struct packed {
		status_t              status;
		logic [VAL_W-1:0]     prior_mean;
		logic [VAL_W-1:0]     new_mean;
		logic [DEV_W-1:0]     new_deviation;
		logic [CNT_OUT_W-1:0] sample_count;
	} res_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
		logic [DIV_W-1:0]      dividend;
		logic [DIV_DW-1:0]     divisor;
	} div_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_RMUL,
		S_RGO,
		S_RWAIT,
		S_BAND,
		S_UPDATE,
		S_MWAIT,
		S_WALK,
		S_VWAIT,
		S_SWAIT,
		S_EMIT
	} state_t;

endpackage

// File: src/wmse_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
// The payload type comes from wmse_pkg at the point of instantiation.
interface wmse_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/wmse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wmse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/wmse_div.sv
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
// Depends on wmse_pkg for the request struct and widths.
module wmse_div import wmse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [DIV_DW-1:0]     rem_q;
	logic [DIV_DW-1:0]     dsr_q;
	logic [DIV_W-1:0]      num_q;
	logic [DIV_W-1:0]      quot_q;
	logic [DIV_DW:0]       trial;
	logic                  qbit;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			quot_q <= {quot_q[DIV_W-2:0], qbit};
			rem_q  <= qbit ? DIV_DW'(trial - {1'b0, dsr_q}) : trial[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: src/wmse_sqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// Depends on wmse_pkg for widths.
module wmse_sqrt import wmse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      operand,
	output logic             done,
	output logic [DEV_W-1:0] root
);

	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        done_q;
	logic [63:0] cand;

	assign cand = res_q + bit_q;

	// step control: 32 steps, bit walks from 2^62 down to 2^0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				bit_q <= 64'd1 << 62;
			end else if (bit_q != '0) begin
				bit_q  <= bit_q >> 2;
				done_q <= (bit_q == 64'd1);
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= operand;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (n_q >= cand) begin
				n_q   <= n_q - cand;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[DEV_W-1:0];

endmodule

// File: src/windowed_mean_stddev_estimator.sv
// Top level: sequencer, estimator state RAM, history ring RAM, divider, root.
// Depends on wmse_pkg, wmse_stream_if, wmse_ram, wmse_div and wmse_sqrt.
//
// Use: observations arrive on the obs stream (task_slot, distance, observed);
// one result beat per observation leaves on the res stream. Slot and distance
// beyond the bank each saturate to their last value. The APB port holds the cap,
// the filter minimum count and the band multiplier; write it only while idle.
// One observation is worked at a time. A beat above the cap goes from load
// straight to emit; when filtering, the band (multiply, then divide) is first
// computed and a beat outside it is dropped too. An accepted beat runs the
// band (when filtering), the mean divide of the SW = 31 + log2(WINDOW) bit sum,
// the ring walk (one RAM read per entry), the variance divide and the square
// root, then emits. The bit-serial divider and the root unit take most of the
// time.
// Results sit in an output register, so the next observation is taken while
// a result waits; a stalled receiver holds the block only when a second
// result is ready. Reset zeroes all estimators at once through per-estimator
// valid bits; ring entries are only used after being written.
module windowed_mean_stddev_estimator import wmse_pkg::*; #(
	parameter int WINDOW    = WINDOW_DEF,
	parameter int NUM_DIST  = NUM_DIST_DEF,
	parameter int NUM_TASKS = NUM_TASKS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	wmse_stream_if.sink   obs,
	wmse_stream_if.source res
);

	localparam int NUM_EST = NUM_TASKS * NUM_DIST;
	localparam int EAW     = (NUM_EST > 1) ? $clog2(NUM_EST) : 1;
	localparam int RDEPTH  = NUM_EST * WINDOW;
	localparam int RAW     = $clog2(RDEPTH);
	localparam int CW      = $clog2(WINDOW + 1);
	localparam int IW      = $clog2(WINDOW);
	localparam int SW      = VAL_W + $clog2(WINDOW);
	localparam int STW     = SW + VAL_W + DEV_W + CW + IW;
	localparam int UPW     = RANGE_W + 1;

	// configuration
	logic [VAL_W-1:0] cap_q;
	logic [5:0]       min_q;
	logic [3:0]       num_q;
	logic [3:0]       den_q;
	logic             cfg_wr;

	// control
	state_t             state_q, state_d;
	logic               out_valid_q;
	logic [NUM_EST-1:0] valid_q;
	logic               rd_v_s1;
	logic               sq_v_s2;

	// working registers
	logic [EAW-1:0]      est_q;
	logic [RAW-1:0]      base_q;
	logic [OBS_W-1:0]    obs_q;
	logic [SW-1:0]       sum_q;
	logic [VAL_W-1:0]    mean_q;
	logic [VAL_W-1:0]    prior_q;
	logic [DEV_W-1:0]    dev_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       widx_q;
	logic [CW-1:0]       walk_q;
	logic [RANGE_W-1:0]  prod_q;
	logic [RANGE_W-1:0]  range_q;
	logic [63:0]         acc_q;
	logic [2*VAL_W-1:0]  sq_s2;
	status_t             status_q;
	res_t                res_q;

	// combinational
	logic               obs_ready;
	logic [EAW-1:0]     est_in;
	logic [RAW-1:0]     base_in;
	int                 slot_i;
	int                 dist_i;
	logic               st_re, st_we;
	logic [STW-1:0]     st_rdata, st_wdata;
	logic               ring_re, ring_we;
	logic [RAW-1:0]     ring_raddr, ring_waddr;
	logic [VAL_W-1:0]   ring_rdata;
	logic               ld_valid;
	logic [SW-1:0]      ld_sum;
	logic [VAL_W-1:0]   ld_mean;
	logic [DEV_W-1:0]   ld_dev;
	logic [CW-1:0]      ld_count;
	logic [IW-1:0]      ld_widx;
	logic               full;
	logic [SW-1:0]      sum_new;
	logic [CW-1:0]      count_new;
	logic [IW-1:0]      widx_new;
	logic [VAL_W-1:0]   lower;
	logic [UPW-1:0]     upper;
	status_t            band_stat;
	logic [VAL_W-1:0]   diff;
	logic               walk_rd;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;
	logic               sq_start;
	logic               sq_done;
	logic [DEV_W-1:0]   sq_root;
	logic [3:0]         den_eff;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			min_q <= MINCOUNT_RESET;
			num_q <= NUM_RESET;
			den_q <= DEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CAP:      cap_q <= pwdata[VAL_W-1:0];
				REG_MINCOUNT: min_q <= pwdata[5:0];
				REG_NUM:      num_q <= pwdata[3:0];
				REG_DEN:      den_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CAP:      prdata = 32'(cap_q);
			REG_MINCOUNT: prdata = 32'(min_q);
			REG_NUM:      prdata = 32'(num_q);
			REG_DEN:      prdata = 32'(den_q);
		endcase
	end

	// ---------------- estimator selection ----------------
	always_comb begin
		slot_i = (int'(obs.data.task_slot) >= NUM_TASKS) ? NUM_TASKS - 1
			: int'(obs.data.task_slot);
		dist_i = (int'(obs.data.distance) >= NUM_DIST) ? NUM_DIST - 1
			: int'(obs.data.distance);
		est_in  = EAW'(slot_i * NUM_DIST + dist_i);
		base_in = RAW'((slot_i * NUM_DIST + dist_i) * WINDOW);
	end

	// ---------------- memories ----------------
	wmse_ram #(.WIDTH(STW), .DEPTH(NUM_EST)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (est_q),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (est_in),
		.rdata (st_rdata)
	);

	wmse_ram #(.WIDTH(VAL_W), .DEPTH(RDEPTH)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (obs_q[VAL_W-1:0]),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// unwritten estimators read as zero
	always_comb begin
		ld_valid = valid_q[est_q];
		{ld_sum, ld_mean, ld_dev, ld_count, ld_widx} = ld_valid ? st_rdata : '0;
	end

	assign st_wdata = {sum_q, mean_q, sq_root, count_q, widx_q};

	// ---------------- arithmetic units ----------------
	wmse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	wmse_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (div_quot),
		.done    (sq_done),
		.root    (sq_root)
	);

	// ring update values
	always_comb begin
		full      = (count_q == CW'(WINDOW));
		sum_new   = sum_q - (full ? SW'(ring_rdata) : '0) + SW'(obs_q[VAL_W-1:0]);
		count_new = full ? count_q : count_q + 1'b1;
		widx_new  = (widx_q == IW'(WINDOW - 1)) ? '0 : widx_q + 1'b1;
	end

	// acceptance band
	always_comb begin
		lower = (range_q < RANGE_W'(mean_q)) ? mean_q - VAL_W'(range_q) : '0;
		upper = UPW'(mean_q) + UPW'(range_q);
		if (obs_q < OBS_W'(lower)) begin
			band_stat = STAT_LOW;
		end else if (obs_q > OBS_W'(upper)) begin
			band_stat = STAT_HIGH;
		end else begin
			band_stat = STAT_OK;
		end
	end

	// distance from the mean for the variance walk
	assign diff = (ring_rdata >= mean_q) ? ring_rdata - mean_q : mean_q - ring_rdata;
	assign den_eff = (den_q == '0) ? 4'd1 : den_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		obs_ready  = 1'b0;
		st_re      = 1'b0;
		st_we      = 1'b0;
		ring_re    = 1'b0;
		ring_we    = 1'b0;
		ring_raddr = base_q + RAW'(ld_widx);
		ring_waddr = base_q + RAW'(widx_q);
		walk_rd    = 1'b0;
		div_req    = '0;
		sq_start   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				obs_ready = 1'b1;
				st_re     = 1'b1;
				if (obs.valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				ring_re = 1'b1;
				if (obs_q > OBS_W'(cap_q)) begin
					state_d = S_EMIT;
				end else if (int'(ld_count) > int'(min_q)) begin
					state_d = S_RMUL;
				end else begin
					state_d = S_UPDATE;
				end
			end
			S_RMUL: begin
				state_d = S_RGO;
			end
			S_RGO: begin
				div_req.start    = 1'b1;
				div_req.steps    = DIV_STEP_W'(RANGE_W);
				div_req.dividend = DIV_W'(prod_q) << (DIV_W - RANGE_W);
				div_req.divisor  = DIV_DW'(den_eff);
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				if (div_done) begin
					state_d = S_BAND;
				end
			end
			S_BAND: begin
				state_d = (band_stat == STAT_OK) ? S_UPDATE : S_EMIT;
			end
			S_UPDATE: begin
				ring_we          = 1'b1;
				div_req.start    = 1'b1;
				div_req.steps    = DIV_STEP_W'(SW);
				div_req.dividend = DIV_W'(sum_new) << (DIV_W - SW);
				div_req.divisor  = DIV_DW'(count_new);
				state_d = S_MWAIT;
			end
			S_MWAIT: begin
				if (div_done) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				walk_rd    = (walk_q < count_q);
				ring_re    = walk_rd;
				ring_raddr = base_q + RAW'(walk_q[IW-1:0]);
				if (!walk_rd && !rd_v_s1 && !sq_v_s2) begin
					div_req.start    = 1'b1;
					div_req.steps    = DIV_STEP_W'(DIV_W);
					div_req.dividend = acc_q;
					div_req.divisor  = DIV_DW'(count_q);
					state_d = S_VWAIT;
				end
			end
			S_VWAIT: begin
				if (div_done) begin
					sq_start = 1'b1;
					state_d  = S_SWAIT;
				end
			end
			S_SWAIT: begin
				if (sq_done) begin
					st_we   = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || res.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign obs.ready = obs_ready;

	// ---------------- control flops ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			rd_v_s1     <= 1'b0;
			sq_v_s2     <= 1'b0;
		end else begin
			rd_v_s1 <= walk_rd;
			sq_v_s2 <= rd_v_s1;
			if (st_we) begin
				valid_q[est_q] <= 1'b1;
			end
			if (state_q == S_EMIT && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		// square and accumulate pipeline of the walk
		if (rd_v_s1) begin
			sq_s2 <= diff * diff;
		end
		if (sq_v_s2) begin
			acc_q <= acc_q + 64'(sq_s2);
		end
		unique case (state_q)
			S_IDLE: begin
				est_q  <= est_in;
				base_q <= base_in;
				obs_q  <= obs.data.observed;
			end
			S_LOAD: begin
				sum_q    <= ld_sum;
				mean_q   <= ld_mean;
				prior_q  <= ld_mean;
				dev_q    <= ld_dev;
				count_q  <= ld_count;
				widx_q   <= ld_widx;
				status_q <= (obs_q > OBS_W'(cap_q)) ? STAT_CAP : STAT_OK;
			end
			S_RMUL: begin
				prod_q <= RANGE_W'(dev_q) * RANGE_W'(num_q);
			end
			S_RWAIT: begin
				if (div_done) begin
					range_q <= div_quot[RANGE_W-1:0];
				end
			end
			S_BAND: begin
				status_q <= band_stat;
			end
			S_UPDATE: begin
				sum_q   <= sum_new;
				count_q <= count_new;
				widx_q  <= widx_new;
			end
			S_MWAIT: begin
				if (div_done) begin
					mean_q <= div_quot[VAL_W-1:0];
					walk_q <= '0;
					acc_q  <= '0;
				end
			end
			S_WALK: begin
				if (walk_rd) begin
					walk_q <= walk_q + 1'b1;
				end
			end
			S_VWAIT: begin
			end
			S_SWAIT: begin
				if (sq_done) begin
					dev_q <= sq_root;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || res.ready) begin
					res_q.status        <= status_q;
					res_q.prior_mean    <= prior_q;
					res_q.new_mean      <= mean_q;
					res_q.new_deviation <= dev_q;
					res_q.sample_count  <= CNT_OUT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

endmodule
